// ----- rtl/fir_pkg.sv -----
// fir_pkg: shared widths, register map constants and control types
// used by every module of the fir filter; no dependencies
`timescale 1ns / 1ps

package fir_pkg;

  localparam int DATA_W    = 32;
  localparam int TAP_REGS  = 8;
  localparam int TAP_AW    = 3;
  localparam int CFG_IDX_W = 8;

  // control that travels with one history/tap read into the mac
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

// ----- rtl/fir_tap_mem.sv -----
// fir_tap_mem: coefficient memory, one write port from the config
// channel and one registered read port; depends on fir_pkg
`timescale 1ns / 1ps

module fir_tap_mem (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  wr_en,
  input  logic [fir_pkg::TAP_AW-1:0]            wr_addr,
  input  logic [fir_pkg::DATA_W-1:0]            wr_data,
  input  logic [fir_pkg::TAP_AW-1:0]            rd_addr,
  output logic [fir_pkg::DATA_W-1:0]            rd_data
);

  logic [fir_pkg::DATA_W-1:0]   mem [fir_pkg::TAP_REGS];
  logic [fir_pkg::TAP_REGS-1:0] written;
  logic [fir_pkg::DATA_W-1:0]   rd_q;
  logic                         rd_written;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // unwritten coefficients read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      rd_written <= written[rd_addr];
    end
  end

  assign rd_data = rd_written ? rd_q : '0;

endmodule

// ----- rtl/fir_hist_mem.sv -----
// fir_hist_mem: circular sample history, one write and one registered
// read port, per-entry valid bits clear it at reset; depends on fir_pkg
`timescale 1ns / 1ps

module fir_hist_mem #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [fir_pkg::DATA_W-1:0]    wr_data,
  input  logic [AW-1:0]                 rd_addr,
  output logic [fir_pkg::DATA_W-1:0]    rd_data
);

  logic [fir_pkg::DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]           filled;
  logic [fir_pkg::DATA_W-1:0] rd_q;
  logic                       rd_filled;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled    <= '0;
      rd_filled <= 1'b0;
    end else begin
      if (wr_en) begin
        filled[wr_addr] <= 1'b1;
      end
      rd_filled <= filled[rd_addr];
    end
  end

  assign rd_data = rd_filled ? rd_q : '0;

endmodule

// ----- rtl/fir_mac.sv -----
// fir_mac: shared multiply-accumulate unit, one tap per cycle, holds the
// finished sum until it is taken; depends on fir_pkg
`timescale 1ns / 1ps

module fir_mac (
  input  logic                          clk,
  input  logic                          rst,
  input  fir_pkg::mac_ctl_t             ctl,
  input  logic [fir_pkg::DATA_W-1:0]    hist_data,
  input  logic [fir_pkg::DATA_W-1:0]    tap_data,
  input  logic                          res_take,
  output logic                          res_vld,
  output logic [fir_pkg::DATA_W-1:0]    res_data
);

  fir_pkg::mac_ctl_t          rd_ctl;
  fir_pkg::mac_ctl_t          prod_ctl;
  logic [fir_pkg::DATA_W-1:0] prod;
  logic [fir_pkg::DATA_W-1:0] acc;
  logic [fir_pkg::DATA_W-1:0] acc_next;

  // ctl lines up with the registered memory read data
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ctl   <= '0;
      prod_ctl <= '0;
      res_vld  <= 1'b0;
    end else begin
      rd_ctl   <= ctl;
      prod_ctl <= rd_ctl;
      if (prod_ctl.vld && prod_ctl.last) begin
        res_vld <= 1'b1;
      end else if (res_take) begin
        res_vld <= 1'b0;
      end
    end
  end

  // low word of the product is the same for signed and unsigned operands
  always_ff @(posedge clk) begin
    prod <= fir_pkg::DATA_W'(hist_data * tap_data);
    if (prod_ctl.vld) begin
      acc <= acc_next;
    end
  end

  assign acc_next = prod_ctl.first ? prod : acc + prod;
  assign res_data = acc;

endmodule

// ----- rtl/fir_filter_top.sv -----
// fir_filter_top: direct-form fir filter, sequencer around the history
// and coefficient memories and the shared mac; depends on fir_pkg
// samples are handled one at a time: the next is accepted only after the
// finished sum of the last has been taken, the single mac walking one tap per
// cycle through the memory read port
// reset: synchronous, clears history and coefficients to zero via valid bits
`timescale 1ns / 1ps

module fir_filter_top #(
  parameter int NUM_TAPS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [fir_pkg::DATA_W-1:0]    sample_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [fir_pkg::DATA_W-1:0]    filtered_out,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fir_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fir_pkg::DATA_W-1:0]           cfg_data
);

  localparam int AW = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_DONE} state_t;

  state_t                     state;
  logic [AW-1:0]              head;
  logic [AW-1:0]              head_next;
  logic [AW-1:0]              tap_cnt;
  logic [AW:0]                addr_sum;
  logic [AW-1:0]              hist_rd_addr;
  logic                       tap_last;
  logic                       in_xfer;
  logic                       tap_wr_en;
  fir_pkg::mac_ctl_t          mac_ctl;
  logic [fir_pkg::DATA_W-1:0] hist_data;
  logic [fir_pkg::DATA_W-1:0] tap_data;
  logic                       res_vld;
  logic [fir_pkg::DATA_W-1:0] res_data;
  logic                       res_take;

  assign in_ready  = (state == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign tap_wr_en = cfg_valid && (cfg_index < fir_pkg::CFG_IDX_W'(fir_pkg::TAP_REGS));

  // newest sample goes one slot below the previous head
  assign head_next = (head == '0) ? AW'(NUM_TAPS - 1) : head - 1'b1;

  assign addr_sum     = {1'b0, head} + {1'b0, tap_cnt};
  assign hist_rd_addr = (addr_sum >= (AW + 1)'(NUM_TAPS)) ?
                        AW'(addr_sum - (AW + 1)'(NUM_TAPS)) : AW'(addr_sum);
  assign tap_last     = (tap_cnt == AW'(NUM_TAPS - 1));

  assign mac_ctl.vld   = (state == ST_ISSUE);
  assign mac_ctl.first = (tap_cnt == '0);
  assign mac_ctl.last  = tap_last;

  assign res_take = res_vld && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      tap_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          tap_cnt <= '0;
          if (in_xfer) begin
            head  <= head_next;
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if (tap_last) begin
            tap_cnt <= '0;
            state   <= ST_DONE;
          end else begin
            tap_cnt <= tap_cnt + 1'b1;
          end
        end
        ST_DONE: begin
          if (res_take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (res_take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      filtered_out <= res_data;
    end
  end

  fir_hist_mem #(
    .DEPTH (NUM_TAPS),
    .AW    (AW)
  ) u_hist (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (in_xfer),
    .wr_addr (head_next),
    .wr_data (sample_in),
    .rd_addr (hist_rd_addr),
    .rd_data (hist_data)
  );

  fir_tap_mem u_taps (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (tap_wr_en),
    .wr_addr (cfg_index[fir_pkg::TAP_AW-1:0]),
    .wr_data (cfg_data),
    .rd_addr (fir_pkg::TAP_AW'(tap_cnt)),
    .rd_data (tap_data)
  );

  fir_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctl       (mac_ctl),
    .hist_data (hist_data),
    .tap_data  (tap_data),
    .res_take  (res_take),
    .res_vld   (res_vld),
    .res_data  (res_data)
  );

`ifndef ASSERT_OFF
  a_no_result_mid_walk: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ISSUE) |-> !res_vld)
    else $error("mac result valid while taps are still being issued");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again before the current sample finished");

  a_head_in_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, head} < (AW + 1)'(NUM_TAPS))
    else $error("history head pointer outside the history depth");

  a_take_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && res_take) |=> (state == ST_IDLE && out_valid))
    else $error("finished sum not moved to the output register");
`endif

endmodule

// ----- tb/sv/fir_filter_top_tb.sv -----
// fir_filter_top_tb: drives samples and tap writes into fir_filter_top and checks
// every filtered output against an in-bench tap/history model or a directed sum
// depends on fir_pkg and fir_filter_top
`timescale 1ns / 1ps

module fir_filter_top_tb;

  localparam int TAPS           = 8;
  localparam int LATENCY        = TAPS + 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 100;

  typedef logic [fir_pkg::DATA_W-1:0] word_t;

  typedef enum logic {ROW_SAMPLE, ROW_TAP_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t                     kind;
    logic [fir_pkg::CFG_IDX_W-1:0] index;
    word_t                         value;
    logic                          typed;
    word_t                         typed_sum;
  } dir_row_t;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 in_valid = 1'b0;
  logic                                 in_ready;
  logic signed [fir_pkg::DATA_W-1:0]    sample_in = '0;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic signed [fir_pkg::DATA_W-1:0]    filtered_out;
  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic [fir_pkg::CFG_IDX_W-1:0]        cfg_index = '0;
  logic [fir_pkg::DATA_W-1:0]           cfg_data = '0;

  word_t    tap_coef [fir_pkg::TAP_REGS];
  word_t    history [fir_pkg::TAP_REGS];
  word_t    expected_sums [$];
  dir_row_t dir_rows [$];
  word_t    want_sum;

  int in_idle_pct    = 0;
  int out_stall_pct  = 0;
  int errors         = 0;
  int samples_sent   = 0;
  int sums_checked   = 0;
  int tap_writes     = 0;
  int stalled_cycles = 0;

  fir_filter_top #(
    .NUM_TAPS(TAPS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample_in(sample_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .filtered_out(filtered_out),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int live_taps();
    int n;
    n = TAPS;
    if (n > fir_pkg::TAP_REGS) n = fir_pkg::TAP_REGS;
    if (n < 1) n = 1;
    return n;
  endfunction

  // shift the new sample in, newest at 0, and sum products mod 2^32
  function automatic word_t shift_and_sum(input word_t s);
    word_t acc;
    int    n;
    n = live_taps();
    for (int k = n - 1; k > 0; k--) history[k] = history[k - 1];
    history[0] = s;
    acc = '0;
    for (int k = 0; k < n; k++) acc = acc + history[k] * tap_coef[k];
    return acc;
  endfunction

  function automatic word_t rand_word();
    word_t w;
    case ($urandom_range(9))
      0: w = 32'h7fff_ffff;
      1: w = 32'h8000_0000;
      2: w = 32'h0000_0000;
      3: w = 32'hffff_ffff;
      4, 5: w = word_t'($signed($urandom_range(200)) - 100);
      default: w = $urandom;
    endcase
    return w;
  endfunction

  task automatic send_sample(input word_t s, input logic typed, input word_t typed_sum);
    word_t predicted;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= s;
    do @(posedge clk); while (!in_ready);
    predicted = shift_and_sum(s);
    expected_sums.push_back(typed ? typed_sum : predicted);
    samples_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_sums.size() != 0);
  endtask

  // caller lowers cfg_valid after the last write of a burst
  task automatic write_tap(input logic [fir_pkg::CFG_IDX_W-1:0] idx, input word_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx < fir_pkg::TAP_REGS) tap_coef[idx] = data;
    tap_writes++;
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_sums.size() == 0) begin
        $error("filtered_out: expected nothing, got %0d", filtered_out);
        errors++;
      end else begin
        want_sum = expected_sums.pop_front();
        if (filtered_out !== want_sum) begin
          $error("filtered_out: expected %0d, got %0d", $signed(want_sum), filtered_out);
          errors++;
        end
        sums_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
        $display("fir_filter_top_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    for (int k = 0; k < fir_pkg::TAP_REGS; k++) begin
      tap_coef[k] = '0;
      history[k]  = '0;
    end

    // taps are zero out of reset
    dir_rows.push_back('{ROW_SAMPLE, 8'd0, 32'h7fff_ffff, 1'b1, 32'h0000_0000});
    dir_rows.push_back('{ROW_SAMPLE, 8'd0, 32'h8000_0000, 1'b1, 32'h0000_0000});
    dir_rows.push_back('{ROW_SAMPLE, 8'd0, 32'hffff_ffff, 1'b1, 32'h0000_0000});
    // unit tap on the newest sample passes it straight through
    dir_rows.push_back('{ROW_TAP_WRITE, 8'd0, 32'h0000_0001, 1'b0, 32'h0});
    dir_rows.push_back('{ROW_SAMPLE, 8'd0, 32'h8000_0000, 1'b1, 32'h8000_0000});
    dir_rows.push_back('{ROW_SAMPLE, 8'd0, 32'h7fff_ffff, 1'b1, 32'h7fff_ffff});
    dir_rows.push_back('{ROW_SAMPLE, 8'd0, 32'h0000_0001, 1'b1, 32'h0000_0001});
    // extreme coefficients, wrapping products and sums
    dir_rows.push_back('{ROW_TAP_WRITE, 8'd0, 32'h7fff_ffff, 1'b0, 32'h0});
    for (int k = 1; k < fir_pkg::TAP_REGS - 1; k++)
      dir_rows.push_back('{ROW_TAP_WRITE, 8'(k), 32'hffff_ffff, 1'b0, 32'h0});
    dir_rows.push_back('{ROW_TAP_WRITE, 8'd7, 32'h8000_0000, 1'b0, 32'h0});
    dir_rows.push_back('{ROW_SAMPLE, 8'd0, 32'h7fff_ffff, 1'b0, 32'h0});
    dir_rows.push_back('{ROW_SAMPLE, 8'd0, 32'h8000_0000, 1'b0, 32'h0});
    dir_rows.push_back('{ROW_SAMPLE, 8'd0, 32'hffff_ffff, 1'b0, 32'h0});
    dir_rows.push_back('{ROW_SAMPLE, 8'd0, 32'h0000_0000, 1'b0, 32'h0});
    dir_rows.push_back('{ROW_SAMPLE, 8'd0, 32'h8000_0000, 1'b0, 32'h0});
    dir_rows.push_back('{ROW_SAMPLE, 8'd0, 32'h8000_0000, 1'b0, 32'h0});
    dir_rows.push_back('{ROW_SAMPLE, 8'd0, 32'h7fff_ffff, 1'b0, 32'h0});
    dir_rows.push_back('{ROW_SAMPLE, 8'd0, 32'h7fff_ffff, 1'b0, 32'h0});
    dir_rows.push_back('{ROW_SAMPLE, 8'd0, 32'h8000_0000, 1'b0, 32'h0});
    // writes past the tap registers must not land anywhere
    dir_rows.push_back('{ROW_TAP_WRITE, 8'd8, 32'h1234_5678, 1'b0, 32'h0});
    dir_rows.push_back('{ROW_TAP_WRITE, 8'd255, 32'hdead_beef, 1'b0, 32'h0});
    dir_rows.push_back('{ROW_SAMPLE, 8'd0, 32'h0000_0003, 1'b0, 32'h0});
    dir_rows.push_back('{ROW_SAMPLE, 8'd0, 32'h8000_0000, 1'b0, 32'h0});

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < dir_rows.size(); i++) begin
      if (dir_rows[i].kind == ROW_TAP_WRITE) begin
        if (i == 0 || dir_rows[i - 1].kind != ROW_TAP_WRITE) drain();
        write_tap(dir_rows[i].index, dir_rows[i].value);
        if (i + 1 == dir_rows.size() || dir_rows[i + 1].kind != ROW_TAP_WRITE)
          cfg_valid <= 1'b0;
      end else begin
        send_sample(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].typed_sum);
      end
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      case (p % 4)
        0: begin
          in_idle_pct   = 0;
          out_stall_pct = 0;
        end
        1: begin
          in_idle_pct   = 50;
          out_stall_pct = 0;
        end
        2: begin
          in_idle_pct   = 0;
          out_stall_pct = 50;
        end
        default: begin
          in_idle_pct   = 33;
          out_stall_pct = 33;
        end
      endcase
      for (int k = 0; k < fir_pkg::TAP_REGS; k++)
        write_tap(fir_pkg::CFG_IDX_W'(k), (p == 0) ? 32'h7fff_ffff :
                                          (p == 1) ? 32'h8000_0000 : rand_word());
      if (p % 2 == 1)
        write_tap(fir_pkg::CFG_IDX_W'($urandom_range(255, fir_pkg::TAP_REGS)), $urandom);
      cfg_valid <= 1'b0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // let the pipeline run dry in the middle of a phase
        if (p == 5 && i == PHASE_ITEMS / 2) drain();
        send_sample(rand_word(), 1'b0, '0);
      end
    end

    drain();
    repeat (LATENCY + 8) @(posedge clk);

    $display("ran %0d samples and %0d tap writes over %0d pacing phases",
             samples_sent, tap_writes, RANDOM_PHASES + 1);
    $display("compared %0d filter outputs, %0d mismatches", sums_checked, errors);
    if (errors == 0) begin
      $display("fir_filter_top_tb OK");
    end else begin
      $display("fir_filter_top_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/fir_pkg.sv
rtl/fir_tap_mem.sv
rtl/fir_hist_mem.sv
rtl/fir_mac.sv
rtl/fir_filter_top.sv
tb/sv/fir_filter_top_tb.sv
